// File: sv/msis_pkg.sv
// ----------------------------------------------------------------------------
// msis_pkg: shared types and constants for the instruction step block
// Operation codes, masks, opcodes, function codes, address selects and controller interface structs.
// ----------------------------------------------------------------------------
package msis_pkg;

  localparam logic [2:0] OP_STEP  = 3'd0;
  localparam logic [2:0] OP_MEMWR = 3'd1;
  localparam logic [2:0] OP_MEMRD = 3'd2;
  localparam logic [2:0] OP_REGWR = 3'd3;
  localparam logic [2:0] OP_REGRD = 3'd4;

  localparam logic [31:0] END_MARK    = 32'hFFFF_FFFF;
  localparam logic [25:0] TARGET_MASK = 26'h3FF_FFFF;
  localparam logic [31:0] REGION_MASK = 32'hF000_0000;
  localparam logic [15:0] HALF_MASK   = 16'hFFFF;

  localparam logic [5:0] OPC_RTYPE = 6'd0;
  localparam logic [5:0] OPC_J     = 6'd2;
  localparam logic [5:0] OPC_JAL   = 6'd3;
  localparam logic [5:0] OPC_BEQ   = 6'd4;
  localparam logic [5:0] OPC_BNE   = 6'd5;
  localparam logic [5:0] OPC_ADDI  = 6'd8;
  localparam logic [5:0] OPC_SLTI  = 6'd10;
  localparam logic [5:0] OPC_ANDI  = 6'd12;
  localparam logic [5:0] OPC_ORI   = 6'd13;
  localparam logic [5:0] OPC_XORI  = 6'd14;
  localparam logic [5:0] OPC_LUI   = 6'd15;
  localparam logic [5:0] OPC_LH    = 6'd33;
  localparam logic [5:0] OPC_LW    = 6'd35;
  localparam logic [5:0] OPC_SH    = 6'd41;
  localparam logic [5:0] OPC_SW    = 6'd43;

  localparam logic [5:0] FN_SLL  = 6'd0;
  localparam logic [5:0] FN_SRL  = 6'd2;
  localparam logic [5:0] FN_JR   = 6'd8;
  localparam logic [5:0] FN_SYS  = 6'd12;
  localparam logic [5:0] FN_ADD  = 6'd32;
  localparam logic [5:0] FN_SUB  = 6'd34;
  localparam logic [5:0] FN_AND  = 6'd36;
  localparam logic [5:0] FN_OR   = 6'd37;
  localparam logic [5:0] FN_XOR  = 6'd38;
  localparam logic [5:0] FN_NOR  = 6'd39;
  localparam logic [5:0] FN_SLT  = 6'd42;
  localparam logic [5:0] FN_SLTU = 6'd43;

  // Memory address source selects
  localparam logic [1:0] MA_ITEM = 2'd0;
  localparam logic [1:0] MA_PC   = 2'd1;
  localparam logic [1:0] MA_EA   = 2'd2;

  typedef struct packed {
    logic       load_item;  // capture request fields
    logic       mem_rd;     // issue memory read
    logic       mem_wr;     // issue memory write
    logic [1:0] mem_sel;    // address source
    logic       mem_plus1;  // use address + 1
    logic       mem_lo;     // write low half of store data
    logic       ir_hi;      // capture read data into ir high half
    logic       ir_lo;      // capture read data into ir low half
    logic       ld_hi;      // capture load high half
    logic       ld_lo;      // capture load low half
    logic       exec;       // perform execute effects
    logic       finish;     // compose the result
  } msis_cmd_t;

  typedef struct packed {
    logic [2:0] operation;
    logic       stopped;
    logic       end_mark;
    logic       is_lh;
    logic       is_lw;
    logic       is_sh;
    logic       is_sw;
  } msis_sts_t;

endpackage

// File: sv/msis_ctrl.sv
// ----------------------------------------------------------------------------
// msis_ctrl: sequencer for one request
// Steps memory accesses for fetch, load and store, then finishes.
// ----------------------------------------------------------------------------
module msis_ctrl import msis_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  msis_sts_t sts,
  output msis_cmd_t cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DISP = 4'd1;
  localparam logic [3:0] S_F0   = 4'd2;
  localparam logic [3:0] S_F1   = 4'd3;
  localparam logic [3:0] S_F2   = 4'd4;
  localparam logic [3:0] S_EXE  = 4'd5;
  localparam logic [3:0] S_M1   = 4'd6;
  localparam logic [3:0] S_M2   = 4'd7;
  localparam logic [3:0] S_MRD  = 4'd8;
  localparam logic [3:0] S_FIN  = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       take_out;

  assign take_out  = out_valid_r & out_ready;
  // the result register parts the two sides; only the finish state waits on it
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r & ~take_out;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid & in_ready) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_DISP;
        end
      end
      S_DISP: begin
        case (sts.operation)
          OP_STEP: state_nxt = sts.stopped ? S_FIN : S_F0;
          OP_MEMWR: begin
            cmd.mem_wr = 1'b1; cmd.mem_sel = MA_ITEM; cmd.mem_lo = 1'b1;
            state_nxt  = S_FIN;
          end
          OP_MEMRD: begin
            cmd.mem_rd = 1'b1; cmd.mem_sel = MA_ITEM;
            state_nxt  = S_MRD;
          end
          default: state_nxt = S_FIN;
        endcase
      end
      S_MRD: begin
        cmd.ld_lo = 1'b1;
        state_nxt = S_FIN;
      end
      S_F0: begin
        cmd.mem_rd = 1'b1; cmd.mem_sel = MA_PC;
        state_nxt  = S_F1;
      end
      S_F1: begin
        cmd.ir_hi  = 1'b1;
        cmd.mem_rd = 1'b1; cmd.mem_sel = MA_PC; cmd.mem_plus1 = 1'b1;
        state_nxt  = S_F2;
      end
      S_F2: begin
        cmd.ir_lo = 1'b1;
        state_nxt = S_EXE;
      end
      S_EXE: begin
        // registers still hold pre-execute values; address from rs
        if (sts.end_mark) begin
          cmd.exec = 1'b1; state_nxt = S_FIN;
        end else if (sts.is_lh | sts.is_lw) begin
          cmd.mem_rd = 1'b1; cmd.mem_sel = MA_EA;
          state_nxt  = S_M1;
        end else if (sts.is_sh | sts.is_sw) begin
          cmd.mem_wr = 1'b1; cmd.mem_sel = MA_EA; cmd.mem_lo = sts.is_sh;
          cmd.mem_rd = 1'b0;
          if (sts.is_sh) begin
            cmd.exec = 1'b1; state_nxt = S_FIN;
          end else begin
            state_nxt = S_M1;
          end
        end else begin
          cmd.exec = 1'b1; state_nxt = S_FIN;
        end
      end
      S_M1: begin
        if (sts.is_lw) begin
          cmd.ld_hi  = 1'b1;
          cmd.mem_rd = 1'b1; cmd.mem_sel = MA_EA; cmd.mem_plus1 = 1'b1;
          state_nxt  = S_M2;
        end else if (sts.is_sw) begin
          cmd.mem_wr = 1'b1; cmd.mem_sel = MA_EA; cmd.mem_plus1 = 1'b1;
          cmd.mem_lo = 1'b1; cmd.exec = 1'b1;
          state_nxt  = S_FIN;
        end else begin
          cmd.ld_lo = 1'b1; cmd.exec = 1'b1;
          state_nxt = S_FIN;
        end
      end
      S_M2: begin
        cmd.ld_lo = 1'b1; cmd.exec = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (~out_valid_r | out_ready) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> state_r == S_IDLE) else $error("ready outside idle");
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid_r) else $error("result not shown");
  a_no_rw: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.mem_rd && cmd.mem_wr)) else $error("read and write together");

endmodule

// File: sv/msis_dp.sv
// ----------------------------------------------------------------------------
// msis_dp: datapath with halfword memory, register file and ALU
// Executes the commands issued by the sequencer.
// ----------------------------------------------------------------------------
module msis_dp import msis_pkg::*; #(
  parameter int MEM_HALFWORDS = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [2:0]  in_operation,
  input  logic [15:0] in_address,
  input  logic [31:0] in_write_data,
  input  msis_cmd_t   cmd,
  output msis_sts_t   sts,
  output logic [31:0] out_read_data,
  output logic [31:0] out_program_counter,
  output logic        out_halted
);

  localparam int AW = $clog2(MEM_HALFWORDS);

  logic [15:0] mem [MEM_HALFWORDS];
  logic [15:0] mem_q_r;

  logic [31:0] regs_r [32];
  logic [31:0] regs_nxt [32];
  logic [31:0] pc_r, pc_nxt;
  logic        stopped_r, stopped_nxt;
  logic [2:0]  op_r;
  logic [15:0] addr_r;
  logic [31:0] wdata_r;
  logic [31:0] ir_r;
  logic [31:0] ld_r;
  logic [31:0] rdata_r;

  logic [31:0] res_rd_r, res_pc_r;
  logic        res_h_r;

  logic [5:0]  opc, fn;
  logic [4:0]  rs, rt, rd, sh;
  logic [15:0] imm;
  logic [31:0] simm, a, b, ea, pc2, maddr, wval, rmux;
  logic [15:0] wdat;

  assign opc  = ir_r[31:26];
  assign rs   = ir_r[25:21];
  assign rt   = ir_r[20:16];
  assign rd   = ir_r[15:11];
  assign sh   = ir_r[10:6];
  assign fn   = ir_r[5:0];
  assign imm  = ir_r[15:0];
  assign simm = {{16{imm[15]}}, imm};
  assign a    = regs_r[rs];
  assign b    = regs_r[rt];
  assign ea   = a + simm;
  assign pc2  = pc_r + 32'd2;

  assign sts.operation = op_r;
  assign sts.stopped   = stopped_r;
  assign sts.end_mark  = (ir_r == END_MARK);
  assign sts.is_lh     = (opc == OPC_LH);
  assign sts.is_lw     = (opc == OPC_LW);
  assign sts.is_sh     = (opc == OPC_SH);
  assign sts.is_sw     = (opc == OPC_SW);

  always_comb begin
    case (cmd.mem_sel)
      MA_PC:   maddr = pc_r;
      MA_EA:   maddr = ea;
      default: maddr = {16'd0, addr_r};
    endcase
    if (cmd.mem_plus1) maddr = maddr + 32'd1;
    if (cmd.mem_sel == MA_ITEM) wdat = wdata_r[15:0];
    else wdat = cmd.mem_lo ? b[15:0] : b[31:16];
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_wr) mem[maddr[AW-1:0]] <= wdat;
    if (cmd.mem_rd) mem_q_r <= mem[maddr[AW-1:0]];
  end

  // Register write value from the executed instruction
  always_comb begin
    regs_nxt    = regs_r;
    pc_nxt      = pc_r;
    stopped_nxt = stopped_r;
    wval        = 32'd0;
    if (cmd.finish && op_r == OP_REGWR && addr_r < 16'd32 && addr_r != 16'd0)
      regs_nxt[addr_r[4:0]] = wdata_r;
    if (cmd.exec) begin
      if (ir_r == END_MARK) begin
        stopped_nxt = 1'b1;
      end else begin
        pc_nxt = pc2;
        case (opc)
          OPC_RTYPE: begin
            case (fn)
              FN_ADD:  regs_nxt[rd] = a + b;
              FN_SUB:  regs_nxt[rd] = a - b;
              FN_SLT:  regs_nxt[rd] = {31'd0, $signed(a) < $signed(b)};
              FN_SLTU: regs_nxt[rd] = {31'd0, a < b};
              FN_AND:  regs_nxt[rd] = a & b;
              FN_OR:   regs_nxt[rd] = a | b;
              FN_XOR:  regs_nxt[rd] = a ^ b;
              FN_NOR:  regs_nxt[rd] = ~(a | b);
              FN_SLL:  regs_nxt[rd] = b << sh;
              FN_SRL:  regs_nxt[rd] = b >> sh;
              FN_JR:   pc_nxt = a;
              FN_SYS:  if (regs_r[2] == 32'd10) stopped_nxt = 1'b1;
              default: ;
            endcase
          end
          OPC_ADDI: regs_nxt[rt] = a + simm;
          OPC_SLTI: regs_nxt[rt] = {31'd0, $signed(a) < $signed(simm)};
          OPC_ANDI: regs_nxt[rt] = a & {16'd0, imm};
          OPC_ORI:  regs_nxt[rt] = a | {16'd0, imm};
          OPC_XORI: regs_nxt[rt] = a ^ {16'd0, imm};
          OPC_LUI:  regs_nxt[rt] = {imm, 16'd0};
          OPC_LH:   regs_nxt[rt] = {{16{mem_q_r[15]}}, mem_q_r};
          OPC_LW:   regs_nxt[rt] = {ld_r[15:0], mem_q_r};
          OPC_BEQ:  if (a == b) pc_nxt = pc2 + {simm[30:0], 1'b0};
          OPC_BNE:  if (a != b) pc_nxt = pc2 + {simm[30:0], 1'b0};
          OPC_J:    pc_nxt = (pc2 & REGION_MASK) | {5'd0, ir_r[25:0] & TARGET_MASK, 1'b0};
          OPC_JAL: begin
            regs_nxt[31] = pc2;
            pc_nxt = (pc2 & REGION_MASK) | {5'd0, ir_r[25:0] & TARGET_MASK, 1'b0};
          end
          default: ;
        endcase
      end
    end
    regs_nxt[0] = wval;
  end

  always_comb begin
    if (op_r == OP_REGRD) rmux = (addr_r < 16'd32) ? regs_r[addr_r[4:0]] : 32'd0;
    else if (op_r == OP_MEMRD) rmux = rdata_r;
    else rmux = 32'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r      <= 32'd0;
      stopped_r <= 1'b0;
      for (int i = 0; i < 32; i++) regs_r[i] <= 32'd0;
    end else begin
      pc_r      <= pc_nxt;
      stopped_r <= stopped_nxt;
      regs_r    <= regs_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_r <= in_operation; addr_r <= in_address; wdata_r <= in_write_data;
    end
    if (cmd.ir_hi) ir_r[31:16] <= mem_q_r;
    if (cmd.ir_lo) ir_r[15:0]  <= mem_q_r;
    if (cmd.ld_hi) ld_r <= {16'd0, mem_q_r};
    if (cmd.ld_lo) rdata_r <= {16'd0, mem_q_r};
    if (cmd.finish) begin
      res_rd_r <= rmux; res_pc_r <= pc_r; res_h_r <= stopped_r;
    end
  end

  assign out_read_data       = res_rd_r;
  assign out_program_counter = res_pc_r;
  assign out_halted          = res_h_r;

  a_r0_zero: assert property (@(posedge clk) disable iff (!rst_n)
    regs_r[0] == 32'd0) else $error("register zero written");
  a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    stopped_r |=> stopped_r) else $error("stop flag cleared");
  a_exec_once: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> !cmd.exec) else $error("double execute");

endmodule

// File: sv/mips_subset_instruction_step.sv
// ----------------------------------------------------------------------------
// mips_subset_instruction_step: small MIPS-like CPU, one request at a time
// Top level joining the sequencer and the datapath.
// ----------------------------------------------------------------------------
// Usage: each input request (in_operation, in_address, in_write_data) is a
// step, a memory halfword write or read, or a register write or read. Each
// request gives exactly one result (out_read_data, out_program_counter,
// out_halted) on a valid/ready channel.
// Register and memory-write requests and a step while stopped go from
// dispatch straight to finish; a memory read adds a read state; a plain
// step fetches in F0, F1 and F2 and executes, and lh, sw and lw add M1
// (lw also M2). The single memory port is why: fetch needs two reads and lw
// or sw two more accesses. One request is processed at a time; the next is
// accepted in the cycle after the previous one finishes.
// Reset (synchronous, rst_n low) clears pc, the stop flag, the register file
// and the handshake state; memory stays undefined until written.
// A stalled receiver holds the result in the output register; the next
// request still runs and waits in the finish state until the result is taken.
// ----------------------------------------------------------------------------
module mips_subset_instruction_step import msis_pkg::*; #(
  parameter int MEM_HALFWORDS = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_operation,
  input  logic [15:0] in_address,
  input  logic [31:0] in_write_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_read_data,
  output logic [31:0] out_program_counter,
  output logic        out_halted
);

  msis_cmd_t cmd;
  msis_sts_t sts;

  msis_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
    .sts(sts), .cmd(cmd)
  );

  msis_dp #(.MEM_HALFWORDS(MEM_HALFWORDS)) u_dp (
    .clk, .rst_n, .in_operation, .in_address, .in_write_data,
    .cmd(cmd), .sts(sts), .out_read_data, .out_program_counter, .out_halted
  );

endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for mips_subset_instruction_step
// Drives memory, register and step requests over valid/ready with random
// gaps and back-pressure, predicts every result with a behavioral CPU and
// compares each result field by field in order.
// ----------------------------------------------------------------------------
module tb;
  import msis_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_operation = OP_STEP;
  logic [15:0] in_address = '0;
  logic [31:0] in_write_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_read_data;
  logic [31:0] out_program_counter;
  logic        out_halted;

  mips_subset_instruction_step dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  typedef struct packed {
    logic [31:0] rd;
    logic [31:0] pcv;
    logic        halt;
  } cpu_result_t;

  typedef struct {
    logic [2:0]  op;
    logic [15:0] addr;
    logic [31:0] data;
    bit          typed;
    logic [31:0] rd;
  } directed_row_t;

  cpu_result_t pending_q[$];
  logic [15:0] cpu_mem[0:65535];
  bit          written[0:65535];
  logic [15:0] written_list[$];
  logic [31:0] cpu_regs[0:31];
  logic [31:0] cpu_pc;
  bit          cpu_stopped;
  bit          fail;
  bit          burst;
  int          results_seen;
  int          idle_cycles;
  int          sent;

  function automatic logic [31:0] sx(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic void set_reg(logic [15:0] r, logic [31:0] v);
    if (r != 0 && r < 32) cpu_regs[r] = v;
  endfunction

  function automatic void mem_store(logic [15:0] a, logic [15:0] v);
    cpu_mem[a] = v;
    if (!written[a]) begin
      written[a] = 1'b1;
      written_list.push_back(a);
    end
  endfunction

  function automatic void execute_instr();
    logic [31:0] ir, imm, simm, a, b, ea;
    logic [5:0]  opc, fn;
    logic [4:0]  rs, rt, rd, sh;
    ir = {cpu_mem[cpu_pc[15:0]], cpu_mem[16'(cpu_pc + 1)]};
    if (ir == END_MARK) begin
      cpu_stopped = 1'b1;
      return;
    end
    cpu_pc += 2;
    opc = ir[31:26]; rs = ir[25:21]; rt = ir[20:16];
    rd = ir[15:11]; sh = ir[10:6]; fn = ir[5:0];
    imm = {16'h0, ir[15:0]};
    simm = sx(ir[15:0]);
    a = cpu_regs[rs];
    b = cpu_regs[rt];
    ea = a + simm;
    case (opc)
      OPC_RTYPE: begin
        case (fn)
          FN_ADD:  set_reg(rd, a + b);
          FN_SUB:  set_reg(rd, a - b);
          FN_SLT:  set_reg(rd, {31'h0, $signed(a) < $signed(b)});
          FN_SLTU: set_reg(rd, {31'h0, a < b});
          FN_AND:  set_reg(rd, a & b);
          FN_OR:   set_reg(rd, a | b);
          FN_XOR:  set_reg(rd, a ^ b);
          FN_NOR:  set_reg(rd, ~(a | b));
          FN_SLL:  set_reg(rd, b << sh);
          FN_SRL:  set_reg(rd, b >> sh);
          FN_JR:   cpu_pc = a;
          FN_SYS:  if (cpu_regs[2] == 10) cpu_stopped = 1'b1;
          default: ;
        endcase
      end
      OPC_ADDI: set_reg(rt, a + simm);
      OPC_SLTI: set_reg(rt, {31'h0, $signed(a) < $signed(simm)});
      OPC_ANDI: set_reg(rt, a & imm);
      OPC_ORI:  set_reg(rt, a | imm);
      OPC_XORI: set_reg(rt, a ^ imm);
      OPC_LUI:  set_reg(rt, imm << 16);
      OPC_LH:   set_reg(rt, sx(cpu_mem[ea[15:0]]));
      OPC_LW:   set_reg(rt, {cpu_mem[ea[15:0]], cpu_mem[16'(ea + 1)]});
      OPC_SH:   mem_store(ea[15:0], b[15:0]);
      OPC_SW: begin
        mem_store(ea[15:0], b[31:16]);
        mem_store(16'(ea + 1), b[15:0]);
      end
      OPC_BEQ: if (a == b) cpu_pc += simm << 1;
      OPC_BNE: if (a != b) cpu_pc += simm << 1;
      OPC_J:   cpu_pc = (cpu_pc & REGION_MASK) | {5'h0, ir[25:0], 1'b0};
      OPC_JAL: begin
        cpu_regs[31] = cpu_pc;
        cpu_pc = (cpu_pc & REGION_MASK) | {5'h0, ir[25:0], 1'b0};
      end
      default: ;
    endcase
    cpu_regs[0] = '0;
  endfunction

  function automatic cpu_result_t apply_request(logic [2:0] op, logic [15:0] addr,
                                                logic [31:0] data);
    cpu_result_t r;
    r.rd = '0;
    case (op)
      OP_STEP:  if (!cpu_stopped) execute_instr();
      OP_MEMWR: mem_store(addr, data[15:0]);
      OP_MEMRD: r.rd = {16'h0, cpu_mem[addr]};
      OP_REGWR: set_reg(addr, data);
      OP_REGRD: r.rd = (addr < 32) ? cpu_regs[addr] : '0;
      default: ;
    endcase
    r.pcv = cpu_pc;
    r.halt = cpu_stopped;
    return r;
  endfunction

  function automatic logic [31:0] rand_instr();
    logic [5:0] opcs[15] = '{OPC_RTYPE, OPC_J, OPC_JAL, OPC_BEQ, OPC_BNE, OPC_ADDI,
                             OPC_SLTI, OPC_ANDI, OPC_ORI, OPC_XORI, OPC_LUI, OPC_LH,
                             OPC_LW, OPC_SH, OPC_SW};
    logic [5:0] fns[13] = '{FN_SLL, FN_SRL, FN_JR, FN_SYS, FN_ADD, FN_SUB, FN_AND,
                            FN_OR, FN_XOR, FN_NOR, FN_SLT, FN_SLTU, 6'd1};
    logic [31:0] w;
    int k;
    w = $urandom;
    k = $urandom_range(0, 21);
    if (k < 15) w[31:26] = opcs[k];
    else if (k < 21) w[31:26] = OPC_RTYPE;
    else w[31:26] = 6'd20;  // unknown opcode
    if (w[31:26] == OPC_RTYPE) w[5:0] = fns[$urandom_range(0, 12)];
    return w;
  endfunction

  task automatic send(input logic [2:0] op, input logic [15:0] addr,
                      input logic [31:0] data, input bit typed = 1'b0,
                      input logic [31:0] typed_rd = '0);
    cpu_result_t r;
    int gap;
    r = apply_request(op, addr, data);
    if (typed) r.rd = typed_rd;
    pending_q.push_back(r);
    sent++;
    gap = burst ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_operation <= op;
    in_address <= addr;
    in_write_data <= data;
    in_valid <= 1'b1;
    do @(posedge clk); while (!(in_ready === 1'b1));
    @(negedge clk);
  endtask

  // Make the next step safe: code at pc must exist and not stop the CPU,
  // and any load must hit halfwords already written.
  task automatic prepare_step();
    bit again;
    logic [15:0] pa, pb;
    logic [31:0] ir, w, ea;
    do begin
      again = 1'b0;
      if (!cpu_stopped) begin
        pa = cpu_pc[15:0];
        pb = pa + 16'd1;
        if (!written[pa] || !written[pb] ||
            {cpu_mem[pa], cpu_mem[pb]} == END_MARK ||
            (cpu_mem[pa][15:10] == OPC_RTYPE && cpu_mem[pb][5:0] == FN_SYS &&
             cpu_regs[2] == 10)) begin
          w = rand_instr();
          send(OP_MEMWR, pa, {16'($urandom), w[31:16]});
          send(OP_MEMWR, pb, {16'($urandom), w[15:0]});
          again = 1'b1;
        end else begin
          ir = {cpu_mem[pa], cpu_mem[pb]};
          ea = cpu_regs[ir[25:21]] + sx(ir[15:0]);
          if ((ir[31:26] == OPC_LH || ir[31:26] == OPC_LW) && !written[ea[15:0]]) begin
            send(OP_MEMWR, ea[15:0], $urandom);
            again = 1'b1;
          end else if (ir[31:26] == OPC_LW && !written[16'(ea + 1)]) begin
            send(OP_MEMWR, 16'(ea + 1), $urandom);
            again = 1'b1;
          end
        end
      end
    end while (again);
  endtask

  always @(posedge clk) begin
    cpu_result_t e;
    if (out_valid === 1'b1 && out_ready === 1'b1) begin
      results_seen++;
      if (pending_q.size() == 0) begin
        $display("%0t: result with none outstanding: rd=%h pc=%h halted=%b", $time,
                 out_read_data, out_program_counter, out_halted);
        fail = 1'b1;
      end else begin
        e = pending_q.pop_front();
        if (out_read_data !== e.rd) begin
          $display("%0t: read_data expected %h actual %h", $time, e.rd, out_read_data);
          fail = 1'b1;
        end
        if (out_program_counter !== e.pcv) begin
          $display("%0t: program_counter expected %h actual %h", $time, e.pcv,
                   out_program_counter);
          fail = 1'b1;
        end
        if (out_halted !== e.halt) begin
          $display("%0t: halted expected %b actual %b", $time, e.halt, out_halted);
          fail = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= 4000) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Receiver: random stalls, one long hold to back the block up.
  initial begin
    int n;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      n = (results_seen == 300) ? 120 : (burst ? 0 : $urandom_range(0, 6));
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid === 1'b1));
      @(negedge clk);
    end
  end

  directed_row_t rows[] = '{
    '{OP_REGRD, 16'd0,     32'h0,         1'b1, 32'h0},
    '{OP_REGWR, 16'd0,     32'hFFFF_FFFF, 1'b1, 32'h0},
    '{OP_REGRD, 16'd0,     32'h0,         1'b1, 32'h0},
    '{OP_REGWR, 16'd31,    32'hFFFF_FFFF, 1'b1, 32'h0},
    '{OP_REGRD, 16'd31,    32'h0,         1'b1, 32'hFFFF_FFFF},
    '{OP_REGWR, 16'd40,    32'h1234_5678, 1'b1, 32'h0},
    '{OP_REGRD, 16'd40,    32'h0,         1'b1, 32'h0},
    '{OP_REGRD, 16'hFFFF,  32'hFFFF_FFFF, 1'b1, 32'h0},
    '{OP_MEMWR, 16'hFFFF,  32'hFFFF_ABCD, 1'b1, 32'h0},
    '{OP_MEMRD, 16'hFFFF,  32'h0,         1'b1, 32'h0000_ABCD},
    '{3'd5,     16'hFFFF,  32'hFFFF_FFFF, 1'b1, 32'h0},
    '{3'd6,     16'h0,     32'h0,         1'b1, 32'h0},
    '{3'd7,     16'hAAAA,  32'h5555_5555, 1'b1, 32'h0},
    '{OP_MEMWR, 16'd0,     32'h0000_2001, 1'b0, 32'h0},  // addi r1, r0, -1
    '{OP_MEMWR, 16'd1,     32'h0000_FFFF, 1'b0, 32'h0},
    '{OP_MEMWR, 16'd2,     32'h0000_0001, 1'b0, 32'h0},  // sll r1, r1, 31
    '{OP_MEMWR, 16'd3,     32'h0000_0FC0, 1'b0, 32'h0},
    '{OP_MEMRD, 16'd0,     32'h0,         1'b1, 32'h0000_2001},
    '{OP_STEP,  16'd0,     32'h0,         1'b0, 32'h0},
    '{OP_REGRD, 16'd1,     32'h0,         1'b1, 32'hFFFF_FFFF},
    '{OP_STEP,  16'd0,     32'h0,         1'b0, 32'h0},
    '{OP_REGRD, 16'd1,     32'h0,         1'b1, 32'h8000_0000}
  };

  initial begin
    int k;
    logic [15:0] a;
    bit paused;
    for (int i = 0; i < 32; i++) cpu_regs[i] = '0;
    cpu_pc = '0;
    cpu_stopped = 1'b0;
    paused = 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (rows[i]) send(rows[i].op, rows[i].addr, rows[i].data, rows[i].typed, rows[i].rd);

    while (sent < 1120) begin
      burst = ((sent / 100) % 4) == 3;
      if (!paused && sent >= 600) begin
        // hold the sender until every outstanding result is back
        paused = 1'b1;
        in_valid <= 1'b0;
        wait (pending_q.size() == 0);
        @(negedge clk);
      end
      k = $urandom_range(0, 99);
      if (k < 55) begin
        prepare_step();
        send(OP_STEP, 16'($urandom), $urandom);
      end else if (k < 70) begin
        a = $urandom_range(0, 1) ? 16'($urandom) : 16'(cpu_pc + $urandom_range(0, 15));
        send(OP_MEMWR, a, $urandom);
      end else if (k < 80) begin
        send(OP_MEMRD, written_list[$urandom_range(0, written_list.size() - 1)], $urandom);
      end else if (k < 88) begin
        a = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
        send(OP_REGWR, a, $urandom);
      end else if (k < 96) begin
        a = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
        send(OP_REGRD, a, $urandom);
      end else begin
        send(3'($urandom_range(5, 7)), 16'($urandom), $urandom);
      end
    end

    // Stop the CPU by the end marker or by the exit service, then keep going.
    burst = 1'b0;
    prepare_step();
    a = cpu_pc[15:0];
    if ($urandom_range(0, 1)) begin
      send(OP_MEMWR, a, 32'h0000_FFFF);
      send(OP_MEMWR, a + 16'd1, 32'hFFFF_FFFF);
    end else begin
      send(OP_REGWR, 16'd2, 32'd10);
      send(OP_MEMWR, a, 32'h0);
      send(OP_MEMWR, a + 16'd1, {26'h0, FN_SYS});
    end
    send(OP_STEP, 16'h0, 32'h0);
    send(OP_STEP, 16'h0, 32'h0);
    send(OP_REGWR, 16'd5, 32'hCAFE_0001);
    send(OP_REGRD, 16'd5, 32'h0);
    send(OP_MEMWR, a + 16'd2, 32'h0000_1357);
    send(OP_MEMRD, a + 16'd2, 32'h0);
    send(OP_STEP, 16'h0, 32'h0);
    in_valid <= 1'b0;

    wait (pending_q.size() == 0);
    repeat (20) @(posedge clk);
    if (!fail) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: mips_subset_instruction_step.f
sv/msis_pkg.sv
sv/msis_ctrl.sv
sv/msis_dp.sv
sv/mips_subset_instruction_step.sv
test/tb.sv
